FILE: hdl/nnsb_pkg.sv
// ----------------------------------------------------------------------------
// nnsb_pkg: shared types and constants of the scaled blitter
// Register map, request classes, pipeline records and reset values.
// ----------------------------------------------------------------------------
package nnsb_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam int CFG_AW = 5;
  localparam int QBITS  = 8;
  localparam int PBITS  = 20;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  localparam logic [2:0] REG_SRC_WIDTH     = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_SCALED_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SCALED_HEIGHT = 3'd3;
  localparam logic [2:0] REG_DST_ORIGIN_X  = 3'd4;
  localparam logic [2:0] REG_DST_ORIGIN_Y  = 3'd5;

  localparam logic [7:0]  RST_SRC_WIDTH     = 8'd128;
  localparam logic [7:0]  RST_SRC_HEIGHT    = 8'd128;
  localparam logic [11:0] RST_SCALED_WIDTH  = 12'd128;
  localparam logic [11:0] RST_SCALED_HEIGHT = 12'd128;
  localparam logic [11:0] RST_DST_ORIGIN_X  = 12'd0;
  localparam logic [11:0] RST_DST_ORIGIN_Y  = 12'd0;

  localparam logic [31:0] KEY_BLACK = 32'h0000_0000;
  localparam logic [31:0] KEY_CLEAR = 32'hFFFF_FF00;

  typedef enum logic [2:0] {
    OP_NONE = 3'b001,
    OP_LOAD = 3'b010,
    OP_DRAW = 3'b100
  } op_t;

  typedef struct packed {
    logic [7:0]  src_width;
    logic [7:0]  src_height;
    logic [11:0] scaled_width;
    logic [11:0] scaled_height;
    logic [11:0] dst_origin_x;
    logic [11:0] dst_origin_y;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [6:0]  load_col;
    logic [6:0]  load_row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] scaled_col;
    logic [11:0] scaled_row;
  } item_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       col;
    logic [7:0]       row;
    logic [31:0]      pix;
    logic [PBITS-1:0] pcol;
    logic [PBITS-1:0] prow;
    logic [12:0]      dcol;
    logic [12:0]      drow;
  } entry_t;

  typedef struct packed {
    entry_t           e;
    logic [PBITS-1:0] rc;
    logic [PBITS-1:0] rr;
    logic [QBITS-1:0] qc;
    logic [QBITS-1:0] qr;
  } stg_t;

  typedef struct packed {
    logic        we;
    logic [12:0] dcol;
    logic [12:0] drow;
    logic [31:0] color;
  } result_t;

endpackage

FILE: hdl/nnsb_fifo.sv
// ----------------------------------------------------------------------------
// nnsb_fifo: small synchronous queue
// Register-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module nnsb_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = nnsb_pkg::MID_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  buf_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          wr, rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign rdata = buf_r[rp_r];

  always_comb begin
    wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    case ({wr, rd})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_nxt;
      end
      if (rd) begin
        rp_r <= rp_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      buf_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: hdl/nnsb_front.sv
// ----------------------------------------------------------------------------
// nnsb_front: request intake and classification
// Registers each accepted request, sorts it into load, draw or no-op, and
// forms the scaled products and destination coordinates for the back end.
// ----------------------------------------------------------------------------
module nnsb_front #(
  parameter int MAX_WIDTH  = nnsb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = nnsb_pkg::MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  nnsb_pkg::item_t  item,
  input  nnsb_pkg::cfg_t   cfg,
  input  logic             q_full,
  output logic             q_push,
  output nnsb_pkg::entry_t q_data
);

  logic             v_r;
  nnsb_pkg::entry_t ent_r, ent_nxt;
  logic             load_ok, in_rng;

  always_comb begin
    load_ok = (32'(item.load_col) < 32'(MAX_WIDTH)) &&
              (32'(item.load_row) < 32'(MAX_HEIGHT));
    in_rng  = (item.scaled_col < cfg.scaled_width) &&
              (item.scaled_row < cfg.scaled_height);

    if (item.func == nnsb_pkg::FUNC_LOAD) begin
      ent_nxt.op = load_ok ? nnsb_pkg::OP_LOAD : nnsb_pkg::OP_NONE;
    end else begin
      ent_nxt.op = in_rng ? nnsb_pkg::OP_DRAW : nnsb_pkg::OP_NONE;
    end
    ent_nxt.col  = {1'b0, item.load_col};
    ent_nxt.row  = {1'b0, item.load_row};
    ent_nxt.pix  = {item.red, item.green, item.blue, item.alpha};
    ent_nxt.pcol = nnsb_pkg::PBITS'(item.scaled_col) * nnsb_pkg::PBITS'(cfg.src_width);
    ent_nxt.prow = nnsb_pkg::PBITS'(item.scaled_row) * nnsb_pkg::PBITS'(cfg.src_height);
    ent_nxt.dcol = 13'(cfg.dst_origin_x) + 13'(item.scaled_col);
    ent_nxt.drow = 13'(cfg.dst_origin_y) + 13'(item.scaled_row);
  end

  assign full   = v_r && q_full;
  assign q_push = v_r && !q_full;
  assign q_data = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (!full) begin
      v_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (!full && push) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

FILE: hdl/nnsb_back.sv
// ----------------------------------------------------------------------------
// nnsb_back: coordinate divider, source store and key test
// Pipelined restoring division maps scaled coordinates to source pixels,
// then the source store is written or read in request order and the color
// key decides whether a destination write is produced.
// ----------------------------------------------------------------------------
module nnsb_back #(
  parameter int MAX_WIDTH  = nnsb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = nnsb_pkg::MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  nnsb_pkg::entry_t  q_data,
  output logic              q_pop,
  input  nnsb_pkg::cfg_t    cfg,
  input  logic              o_full,
  output logic              o_push,
  output nnsb_pkg::result_t o_data
);

  localparam int NSTG  = nnsb_pkg::QBITS;
  localparam int PB    = nnsb_pkg::PBITS;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              adv;
  nnsb_pkg::stg_t    st_r   [NSTG+1];
  nnsb_pkg::stg_t    st_nxt [NSTG+1];
  logic [NSTG:0]     vld_r;
  logic [PB-1:0]     dvc, dvr;

  nnsb_pkg::stg_t    lst;
  logic              is_load, hit;
  logic [7:0]        mcol, mrow;
  logic [AW-1:0]     maddr;
  logic [31:0]       src_img_r [DEPTH];
  logic [31:0]       rd_r;
  logic              m_vld_r, m_hit_r;
  logic [12:0]       m_dcol_r, m_drow_r;
  logic              we;

  assign adv   = !o_full;
  assign q_pop = adv && !q_empty;
  assign dvc   = PB'(cfg.scaled_width);
  assign dvr   = PB'(cfg.scaled_height);

  always_comb begin
    st_nxt[0].e  = q_data;
    st_nxt[0].rc = q_data.pcol;
    st_nxt[0].rr = q_data.prow;
    st_nxt[0].qc = '0;
    st_nxt[0].qr = '0;
    for (int s = 0; s < NSTG; s++) begin
      st_nxt[s+1] = st_r[s];
      if (st_r[s].rc >= (dvc << (NSTG - 1 - s))) begin
        st_nxt[s+1].rc               = st_r[s].rc - (dvc << (NSTG - 1 - s));
        st_nxt[s+1].qc[NSTG - 1 - s] = 1'b1;
      end
      if (st_r[s].rr >= (dvr << (NSTG - 1 - s))) begin
        st_nxt[s+1].rr               = st_r[s].rr - (dvr << (NSTG - 1 - s));
        st_nxt[s+1].qr[NSTG - 1 - s] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-1:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s <= NSTG; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign lst = st_r[NSTG];

  always_comb begin
    is_load = (lst.e.op == nnsb_pkg::OP_LOAD);
    hit     = (lst.e.op == nnsb_pkg::OP_DRAW) &&
              (lst.qc < cfg.src_width) && (lst.qr < cfg.src_height) &&
              (32'(lst.qc) < 32'(MAX_WIDTH)) && (32'(lst.qr) < 32'(MAX_HEIGHT));
    mcol    = is_load ? lst.e.col : lst.qc;
    mrow    = is_load ? lst.e.row : lst.qr;
    maddr   = AW'(32'(mrow) * 32'(MAX_WIDTH) + 32'(mcol));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (vld_r[NSTG] && is_load) begin
        src_img_r[maddr] <= lst.e.pix;
      end
      rd_r <= src_img_r[maddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_hit_r  <= hit;
      m_dcol_r <= lst.e.dcol;
      m_drow_r <= lst.e.drow;
    end
  end

  always_comb begin
    we           = m_hit_r && (rd_r != nnsb_pkg::KEY_BLACK) &&
                   (rd_r != nnsb_pkg::KEY_CLEAR);
    o_data.we    = we;
    o_data.dcol  = we ? m_dcol_r : '0;
    o_data.drow  = we ? m_drow_r : '0;
    o_data.color = we ? rd_r : '0;
  end

  assign o_push = adv && m_vld_r;

endmodule

FILE: hdl/nearest_neighbor_scaled_blit.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_scaled_blit: nearest-neighbor scaled blit with color key
// Requests enter through a queue-like port (push/full) and results leave
// through another (empty/pop). A load request stores one source pixel; a
// draw request maps a scaled coordinate back to a source pixel and yields a
// destination write if both lie in range and the pixel is not keyed
// transparent. Every request produces exactly one result, in order.
// One request is taken per cycle unless the back end holds; the rate is set
// by the eight-stage division pipeline and the single-port source store,
// which serves one load or one draw each cycle.
// Registers are to be written over the APB port only while the block is
// idle; the block itself does not enforce this.
// Reset empties both queues and the pipeline and loads the register
// defaults; the source store is not cleared and must be loaded before it is
// drawn from. When the receiver stops popping, the back end holds, the
// middle queue fills and full rises; nothing is lost.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaled_blit #(
  parameter int MAX_WIDTH  = nnsb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = nnsb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nnsb_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_func,
  input  logic [6:0]                  in_load_col,
  input  logic [6:0]                  in_load_row,
  input  logic [7:0]                  in_red,
  input  logic [7:0]                  in_green,
  input  logic [7:0]                  in_blue,
  input  logic [7:0]                  in_alpha,
  input  logic [11:0]                 in_scaled_col,
  input  logic [11:0]                 in_scaled_row,
  output logic                        empty,
  input  logic                        pop,
  output logic                        out_write_enable,
  output logic [12:0]                 out_dst_col,
  output logic [12:0]                 out_dst_row,
  output logic [31:0]                 out_color
);

  localparam int EW = $bits(nnsb_pkg::entry_t);
  localparam int RW = $bits(nnsb_pkg::result_t);

  nnsb_pkg::cfg_t    cfg_r;
  logic [2:0]        ridx;
  logic              cfg_we;
  nnsb_pkg::item_t   item;
  logic              mq_push, mq_full, mq_pop, mq_empty;
  nnsb_pkg::entry_t  mq_wdata, mq_rdata;
  logic              oq_push, oq_full;
  nnsb_pkg::result_t oq_wdata, oq_rdata;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width     <= nnsb_pkg::RST_SRC_WIDTH;
      cfg_r.src_height    <= nnsb_pkg::RST_SRC_HEIGHT;
      cfg_r.scaled_width  <= nnsb_pkg::RST_SCALED_WIDTH;
      cfg_r.scaled_height <= nnsb_pkg::RST_SCALED_HEIGHT;
      cfg_r.dst_origin_x  <= nnsb_pkg::RST_DST_ORIGIN_X;
      cfg_r.dst_origin_y  <= nnsb_pkg::RST_DST_ORIGIN_Y;
    end else if (cfg_we) begin
      case (ridx)
        nnsb_pkg::REG_SRC_WIDTH:     cfg_r.src_width     <= pwdata[7:0];
        nnsb_pkg::REG_SRC_HEIGHT:    cfg_r.src_height    <= pwdata[7:0];
        nnsb_pkg::REG_SCALED_WIDTH:  cfg_r.scaled_width  <= pwdata[11:0];
        nnsb_pkg::REG_SCALED_HEIGHT: cfg_r.scaled_height <= pwdata[11:0];
        nnsb_pkg::REG_DST_ORIGIN_X:  cfg_r.dst_origin_x  <= pwdata[11:0];
        nnsb_pkg::REG_DST_ORIGIN_Y:  cfg_r.dst_origin_y  <= pwdata[11:0];
        default:                     cfg_r               <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      nnsb_pkg::REG_SRC_WIDTH:     prdata = 32'(cfg_r.src_width);
      nnsb_pkg::REG_SRC_HEIGHT:    prdata = 32'(cfg_r.src_height);
      nnsb_pkg::REG_SCALED_WIDTH:  prdata = 32'(cfg_r.scaled_width);
      nnsb_pkg::REG_SCALED_HEIGHT: prdata = 32'(cfg_r.scaled_height);
      nnsb_pkg::REG_DST_ORIGIN_X:  prdata = 32'(cfg_r.dst_origin_x);
      nnsb_pkg::REG_DST_ORIGIN_Y:  prdata = 32'(cfg_r.dst_origin_y);
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    item.func       = in_func;
    item.load_col   = in_load_col;
    item.load_row   = in_load_row;
    item.red        = in_red;
    item.green      = in_green;
    item.blue       = in_blue;
    item.alpha      = in_alpha;
    item.scaled_col = in_scaled_col;
    item.scaled_row = in_scaled_row;
  end

  nnsb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .cfg    (cfg_r),
    .q_full (mq_full),
    .q_push (mq_push),
    .q_data (mq_wdata)
  );

  nnsb_fifo #(
    .W     (EW),
    .DEPTH (nnsb_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  nnsb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (mq_empty),
    .q_data  (mq_rdata),
    .q_pop   (mq_pop),
    .cfg     (cfg_r),
    .o_full  (oq_full),
    .o_push  (oq_push),
    .o_data  (oq_wdata)
  );

  nnsb_fifo #(
    .W     (RW),
    .DEPTH (nnsb_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty)
  );

  assign out_write_enable = oq_rdata.we;
  assign out_dst_col      = oq_rdata.dcol;
  assign out_dst_row      = oq_rdata.drow;
  assign out_color        = oq_rdata.color;

  a_key_never_written: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_write_enable) |->
      (out_color != nnsb_pkg::KEY_BLACK) && (out_color != nnsb_pkg::KEY_CLEAR))
    else $error("keyed color produced a destination write");

  a_no_write_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_write_enable) |->
      (out_color == '0) && (out_dst_col == '0) && (out_dst_row == '0))
    else $error("result without write carries nonzero fields");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  a_mid_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (mq_full && !mq_push))
    else $error("front stalls while the middle queue has room");

endmodule

FILE: dv/nearest_neighbor_scaled_blit_test.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_scaled_blit_test: self-checking bench for the scaled blit
// Loads source pixels and draws scaled pixels through the request queue,
// predicts every result from a local copy of the source store and registers,
// and compares each popped result in order. Directed requests cover defaults,
// color keys and extreme register settings; random rounds then mix loads and
// draws, in and out of range, under random settings with random idling on both sides.
// ----------------------------------------------------------------------------
module nearest_neighbor_scaled_blit_test;

  localparam int STORE_DEPTH = nnsb_pkg::MAX_WIDTH_DEF * nnsb_pkg::MAX_HEIGHT_DEF;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [nnsb_pkg::CFG_AW-1:0] paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;
  logic                        push = 1'b0;
  logic                        full;
  logic                        in_func = 1'b0;
  logic [6:0]                  in_load_col = '0;
  logic [6:0]                  in_load_row = '0;
  logic [7:0]                  in_red = '0;
  logic [7:0]                  in_green = '0;
  logic [7:0]                  in_blue = '0;
  logic [7:0]                  in_alpha = '0;
  logic [11:0]                 in_scaled_col = '0;
  logic [11:0]                 in_scaled_row = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic                        out_write_enable;
  logic [12:0]                 out_dst_col;
  logic [12:0]                 out_dst_row;
  logic [31:0]                 out_color;

  nnsb_pkg::cfg_t    blit_cfg;
  logic [31:0]       src_pixels [STORE_DEPTH];
  bit                src_loaded [STORE_DEPTH];
  nnsb_pkg::result_t pending_writes [$];
  int                mismatches = 0;
  bit                send_calm = 1'b0;
  bit                take_calm = 1'b0;

  nearest_neighbor_scaled_blit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .in_func          (in_func),
    .in_load_col      (in_load_col),
    .in_load_row      (in_load_row),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_alpha         (in_alpha),
    .in_scaled_col    (in_scaled_col),
    .in_scaled_row    (in_scaled_row),
    .empty            (empty),
    .pop              (pop),
    .out_write_enable (out_write_enable),
    .out_dst_col      (out_dst_col),
    .out_dst_row      (out_dst_row),
    .out_color        (out_color)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_idle(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(0, 7))
      0: return nnsb_pkg::KEY_BLACK;
      1: return nnsb_pkg::KEY_CLEAR;
      2: return nnsb_pkg::KEY_CLEAR ^ (32'd1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Returns 1 when a draw at this scaled position reads the source store.
  function automatic bit source_of(logic [11:0] scol, logic [11:0] srow,
                                   output int unsigned pos);
    int unsigned mc;
    int unsigned mr;
    pos = 0;
    if (scol >= blit_cfg.scaled_width || srow >= blit_cfg.scaled_height) return 0;
    mc = 32'(scol);
    mr = 32'(srow);
    mc = mc * blit_cfg.src_width / blit_cfg.scaled_width;
    mr = mr * blit_cfg.src_height / blit_cfg.scaled_height;
    if (mc >= blit_cfg.src_width || mr >= blit_cfg.src_height) return 0;
    if (mc >= nnsb_pkg::MAX_WIDTH_DEF || mr >= nnsb_pkg::MAX_HEIGHT_DEF) return 0;
    pos = mr * nnsb_pkg::MAX_WIDTH_DEF + mc;
    return 1;
  endfunction

  function automatic nnsb_pkg::result_t blit_predict(nnsb_pkg::item_t it);
    nnsb_pkg::result_t r;
    int unsigned       pos;
    logic [31:0]       pix;
    r = '0;
    if (it.func == nnsb_pkg::FUNC_LOAD) begin
      pos = 32'(it.load_row) * nnsb_pkg::MAX_WIDTH_DEF + 32'(it.load_col);
      src_pixels[pos] = {it.red, it.green, it.blue, it.alpha};
      src_loaded[pos] = 1'b1;
      return r;
    end
    if (!source_of(it.scaled_col, it.scaled_row, pos)) return r;
    pix = src_pixels[pos];
    if (pix == nnsb_pkg::KEY_BLACK || pix == nnsb_pkg::KEY_CLEAR) return r;
    r.we    = 1'b1;
    r.dcol  = {1'b0, blit_cfg.dst_origin_x} + {1'b0, it.scaled_col};
    r.drow  = {1'b0, blit_cfg.dst_origin_y} + {1'b0, it.scaled_row};
    r.color = pix;
    return r;
  endfunction

  task automatic send_item(nnsb_pkg::item_t it);
    int gap;
    gap = pick_idle(send_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    in_func       <= it.func;
    in_load_col   <= it.load_col;
    in_load_row   <= it.load_row;
    in_red        <= it.red;
    in_green      <= it.green;
    in_blue       <= it.blue;
    in_alpha      <= it.alpha;
    in_scaled_col <= it.scaled_col;
    in_scaled_row <= it.scaled_row;
    do @(posedge clk); while (full !== 1'b0);
    pending_writes.push_back(blit_predict(it));
  endtask

  task automatic load_pixel(int col, int row, logic [31:0] color);
    nnsb_pkg::item_t it;
    it = '0;
    it.func       = nnsb_pkg::FUNC_LOAD;
    it.load_col   = 7'(col);
    it.load_row   = 7'(row);
    {it.red, it.green, it.blue, it.alpha} = color;
    it.scaled_col = 12'($urandom_range(0, 4095));
    it.scaled_row = 12'($urandom_range(0, 4095));
    send_item(it);
  endtask

  // A draw that would read a never-loaded pixel is preceded by a load of it.
  task automatic draw_pixel(int col, int row);
    nnsb_pkg::item_t it;
    int unsigned     pos;
    it = '0;
    it.func       = nnsb_pkg::FUNC_DRAW;
    it.scaled_col = 12'(col);
    it.scaled_row = 12'(row);
    if (source_of(it.scaled_col, it.scaled_row, pos) && !src_loaded[pos])
      load_pixel(pos % nnsb_pkg::MAX_WIDTH_DEF, pos / nnsb_pkg::MAX_WIDTH_DEF, pick_color());
    it.load_col = 7'($urandom_range(0, 127));
    it.load_row = 7'($urandom_range(0, 127));
    {it.red, it.green, it.blue, it.alpha} = $urandom;
    send_item(it);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      nnsb_pkg::REG_SRC_WIDTH:     blit_cfg.src_width     = value[7:0];
      nnsb_pkg::REG_SRC_HEIGHT:    blit_cfg.src_height    = value[7:0];
      nnsb_pkg::REG_SCALED_WIDTH:  blit_cfg.scaled_width  = value[11:0];
      nnsb_pkg::REG_SCALED_HEIGHT: blit_cfg.scaled_height = value[11:0];
      nnsb_pkg::REG_DST_ORIGIN_X:  blit_cfg.dst_origin_x  = value[11:0];
      nnsb_pkg::REG_DST_ORIGIN_Y:  blit_cfg.dst_origin_y  = value[11:0];
      default: ;
    endcase
  endtask

  task automatic configure(int sw, int sh, int scw, int sch, int ox, int oy);
    drain();
    write_reg(nnsb_pkg::REG_SRC_WIDTH, sw);
    write_reg(nnsb_pkg::REG_SRC_HEIGHT, sh);
    write_reg(nnsb_pkg::REG_SCALED_WIDTH, scw);
    write_reg(nnsb_pkg::REG_SCALED_HEIGHT, sch);
    write_reg(nnsb_pkg::REG_DST_ORIGIN_X, ox);
    write_reg(nnsb_pkg::REG_DST_ORIGIN_Y, oy);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    load_pixel(0, 0, 32'h0102_0304);
    load_pixel(127, 127, 32'hFFFF_FFFF);
    load_pixel(1, 0, nnsb_pkg::KEY_BLACK);
    load_pixel(2, 0, nnsb_pkg::KEY_CLEAR);
    load_pixel(3, 0, nnsb_pkg::KEY_CLEAR | 32'd1);
    draw_pixel(0, 0);
    draw_pixel(127, 127);
    draw_pixel(1, 0);
    draw_pixel(2, 0);
    draw_pixel(3, 0);
    draw_pixel(128, 5);
    draw_pixel(5, 4095);
  endtask

  task automatic test_extreme_config();
    configure(1, 1, 4095, 4095, 4095, 4095);
    draw_pixel(4094, 4094);
    draw_pixel(0, 0);
    draw_pixel(4095, 0);
    configure(128, 128, 0, 0, 0, 0);
    draw_pixel(0, 0);
    configure(0, 0, 64, 64, 0, 0);
    draw_pixel(3, 3);
    configure(255, 200, 100, 100, 7, 9);
    draw_pixel(70, 10);
    draw_pixel(10, 10);
  endtask

  function automatic int pick_src_size();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 16);
  endfunction

  function automatic int pick_scaled_size(int src);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4095;
      2, 3: return $urandom_range(1, 300);
      default: return src * $urandom_range(1, 8) / $urandom_range(1, 4);
    endcase
  endfunction

  task automatic test_random_blits();
    int sw;
    int sh;
    int scw;
    int sch;
    int kind;
    for (int round = 0; round < 8; round++) begin
      sw  = pick_src_size();
      sh  = pick_src_size();
      scw = pick_scaled_size(sw);
      sch = pick_scaled_size(sh);
      configure(sw, sh, scw, sch, $urandom_range(0, 4095), $urandom_range(0, 4095));
      for (int n = 0; n < 75; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 25)
          load_pixel($urandom_range(0, sw - 1), $urandom_range(0, sh - 1), pick_color());
        else if (kind < 30)
          load_pixel($urandom_range(0, 127), $urandom_range(0, 127), pick_color());
        else if (kind < 90 && scw > 0 && sch > 0)
          draw_pixel($urandom_range(0, scw - 1), $urandom_range(0, sch - 1));
        else
          draw_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
    end
  endtask

  initial begin
    nnsb_pkg::result_t seen;
    nnsb_pkg::result_t want;
    int                stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = pick_idle(take_calm);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty !== 1'b0);
      seen.we    = out_write_enable;
      seen.dcol  = out_dst_col;
      seen.drow  = out_dst_row;
      seen.color = out_color;
      if (pending_writes.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: we=%0d col=%0d row=%0d color=%h",
                   seen.we, seen.dcol, seen.drow, seen.color);
        mismatches++;
      end else begin
        want = pending_writes.pop_front();
        if (seen !== want) begin
          if (mismatches < 10)
            $display("mismatch we/col/row/color: expected %0d %0d %0d %h, got %0d %0d %0d %h",
                     want.we, want.dcol, want.drow, want.color,
                     seen.we, seen.dcol, seen.drow, seen.color);
          mismatches++;
        end
      end
    end
  end

  initial begin
    blit_cfg.src_width     = nnsb_pkg::RST_SRC_WIDTH;
    blit_cfg.src_height    = nnsb_pkg::RST_SRC_HEIGHT;
    blit_cfg.scaled_width  = nnsb_pkg::RST_SCALED_WIDTH;
    blit_cfg.scaled_height = nnsb_pkg::RST_SCALED_HEIGHT;
    blit_cfg.dst_origin_x  = nnsb_pkg::RST_DST_ORIGIN_X;
    blit_cfg.dst_origin_y  = nnsb_pkg::RST_DST_ORIGIN_Y;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_extreme_config();
    test_random_blits();
    drain();
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/nnsb_pkg.sv
hdl/nnsb_fifo.sv
hdl/nnsb_front.sv
hdl/nnsb_back.sv
hdl/nearest_neighbor_scaled_blit.sv
dv/nearest_neighbor_scaled_blit_test.sv
